>>> rtl/core/twa_pkg.sv
// ----------------------------------------------------------------------------
// twa_pkg
// Shared types and constants of the sliding time-window averager.
// ----------------------------------------------------------------------------
package twa_pkg;

    localparam int TIME_W       = 17;
    localparam int RATE_W       = 32;
    localparam int COUNT_W      = 10;
    localparam int CAPACITY_DEF = 512;

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    // register index is paddr[2] (word addresses 0 and 4)
    localparam logic REG_WINDOW = 1'b0;
    localparam logic [TIME_W-1:0] WINDOW_RESET = 17'd300;

    // stream payloads
    localparam int S_TDATA_W = 56;  // 17 + 32 = 49 bits, padded to 7 bytes
    localparam int M_TDATA_W = 48;  // 32 + 10 = 42 bits, padded to 6 bytes

    typedef struct packed {
        logic [RATE_W-1:0] rate;
        logic [TIME_W-1:0] stamp;
    } entry_t;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_EVICT  = 4'b0010,
        ST_DIVIDE = 4'b0100,
        ST_LOAD   = 4'b1000
    } state_t;

endpackage

>>> rtl/core/time_window_average.sv
// ----------------------------------------------------------------------------
// time_window_average
// Sliding time-window average of timestamped Q16.16 rate samples.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: one transfer per sample, tdata = {rate_sample,
//   arrival_time}. Arrival times should not decrease from one sample to the
//   next. Output stream m_*: one transfer per sample with the truncated mean
//   of the samples still inside the window, their count, and in tuser the
//   overflow flag (oldest sample dropped because the ring was full).
//   APB port: register 0 (byte address 0) is window_seconds, reset 300; a
//   value of 0 acts as 1. Write it only while the block is idle.
// Sequence:
//   A sample is accepted in ST_IDLE, then ST_EVICT walks the ring from the
//   head (one ring read per cycle) and ends with the append, ST_DIVIDE runs
//   the bit-serial division of the running sum by the count and ST_LOAD loads
//   the output register. The next sample is accepted only back in ST_IDLE,
//   once the result of the last one has gone into the output register.
// Reset and stall:
//   rst_n clears the ring pointers, count and sum; no clearing pass is run.
//   A stalled receiver holds the output register; the next sample is still
//   accepted and worked on, and its result waits until the register frees.
// ----------------------------------------------------------------------------
module time_window_average #(
    parameter int CAPACITY = twa_pkg::CAPACITY_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [twa_pkg::S_TDATA_W-1:0]     s_tdata,   // [16:0] arrival_time, [48:17] rate_sample
    // output stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [twa_pkg::M_TDATA_W-1:0]     m_tdata,   // [31:0] average_rate, [41:32] held_count
    output logic                              m_tuser,   // [0] overflow
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [twa_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [twa_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [twa_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);

    localparam int TIME_W  = twa_pkg::TIME_W;
    localparam int RATE_W  = twa_pkg::RATE_W;
    localparam int COUNT_W = twa_pkg::COUNT_W;
    localparam int PTR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int OCC_W   = $clog2(CAPACITY + 1);
    localparam int SUM_W   = RATE_W + OCC_W;
    localparam int ENTRY_W = $bits(twa_pkg::entry_t);

    // ------------------------------------------------------------------------
    // State registers
    // ------------------------------------------------------------------------
    twa_pkg::state_t   state_reg, state_next;
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [PTR_W-1:0]  tail_reg, tail_next;
    logic [OCC_W-1:0]  occ_reg, occ_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic              ovf_reg, ovf_next;
    logic [TIME_W-1:0] window_reg, window_next;

    // sample under work
    logic [TIME_W-1:0] now_reg, now_next;
    logic [RATE_W-1:0] rate_reg, rate_next;
    logic [TIME_W-1:0] win_reg, win_next;

    // output register
    logic                         m_tvalid_reg, m_tvalid_next;
    logic [twa_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                         m_tuser_reg, m_tuser_next;

    // ------------------------------------------------------------------------
    // Ring store and divider
    // ------------------------------------------------------------------------
    twa_pkg::entry_t   wr_entry;
    twa_pkg::entry_t   rd_entry;
    logic [ENTRY_W-1:0] rd_bits;
    logic              ram_we;
    logic              div_start;
    logic              div_done;
    logic [RATE_W-1:0] div_quotient;

    // The read port always follows the next head, so the head entry is on
    // rd_entry in the cycle after the head moves. The only write that can
    // hit the head lands while the divider runs, long before the next read.
    twa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail_reg),
        .wdata (wr_entry),
        .raddr (head_next),
        .rdata (rd_bits)
    );

    assign rd_entry = twa_pkg::entry_t'(rd_bits);

    twa_div #(
        .OCC_W (OCC_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_next),
        .divisor  (occ_next),
        .quotient (div_quotient),
        .done     (div_done)
    );

    // ------------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------------
    logic cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        window_next = window_reg;
        if (cfg_write && (paddr[2] == twa_pkg::REG_WINDOW))
        begin
            window_next = pwdata[TIME_W-1:0];
        end
    end

    assign prdata = (paddr[2] == twa_pkg::REG_WINDOW)
                    ? twa_pkg::APB_DATA_W'(window_reg) : '0;

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    logic              in_xfer;
    logic              has_age;
    logic              aged;
    logic              full;
    logic [TIME_W-1:0] age;
    logic [PTR_W-1:0]  head_inc;
    logic [PTR_W-1:0]  tail_inc;

    assign s_tready = (state_reg == twa_pkg::ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;

    assign has_age  = (occ_reg != '0) && (now_reg >= rd_entry.stamp);
    assign age      = now_reg - rd_entry.stamp;
    assign aged     = has_age && (age >= win_reg);
    assign full     = (occ_reg == OCC_W'(CAPACITY));
    assign head_inc = (head_reg == PTR_W'(CAPACITY - 1)) ? '0 : head_reg + 1'b1;
    assign tail_inc = (tail_reg == PTR_W'(CAPACITY - 1)) ? '0 : tail_reg + 1'b1;

    assign wr_entry.rate  = rate_reg;
    assign wr_entry.stamp = now_reg;

    always_comb
    begin
        state_next    = state_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        occ_next      = occ_reg;
        sum_next      = sum_reg;
        ovf_next      = ovf_reg;
        now_next      = now_reg;
        rate_next     = rate_reg;
        win_next      = win_reg;
        ram_we        = 1'b0;
        div_start     = 1'b0;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        // drop the output once taken
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            twa_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    now_next   = s_tdata[TIME_W-1:0];
                    rate_next  = s_tdata[TIME_W+RATE_W-1:TIME_W];
                    win_next   = (window_reg == '0) ? TIME_W'(1) : window_reg;
                    state_next = twa_pkg::ST_EVICT;
                end
            end

            twa_pkg::ST_EVICT:
            begin
                if (aged)
                begin
                    // evict the head, look at the next one
                    head_next = head_inc;
                    occ_next  = occ_reg - 1'b1;
                    sum_next  = sum_reg - SUM_W'(rd_entry.rate);
                end
                else
                begin
                    // append; on a full ring drop the head in the same cycle
                    ram_we    = 1'b1;
                    tail_next = tail_inc;
                    ovf_next  = full;
                    if (full)
                    begin
                        head_next = head_inc;
                        sum_next  = sum_reg - SUM_W'(rd_entry.rate) + SUM_W'(rate_reg);
                    end
                    else
                    begin
                        occ_next  = occ_reg + 1'b1;
                        sum_next  = sum_reg + SUM_W'(rate_reg);
                    end
                    div_start  = 1'b1;
                    state_next = twa_pkg::ST_DIVIDE;
                end
            end

            twa_pkg::ST_DIVIDE:
            begin
                if (div_done)
                begin
                    state_next = twa_pkg::ST_LOAD;
                end
            end

            twa_pkg::ST_LOAD:
            begin
                // hold until the output register is free
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = twa_pkg::M_TDATA_W'({COUNT_W'(occ_reg), div_quotient});
                    m_tuser_next  = ovf_reg;
                    state_next    = twa_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = twa_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= twa_pkg::ST_IDLE;
            head_reg     <= '0;
            tail_reg     <= '0;
            occ_reg      <= '0;
            sum_reg      <= '0;
            ovf_reg      <= 1'b0;
            window_reg   <= twa_pkg::WINDOW_RESET;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            occ_reg      <= occ_next;
            sum_reg      <= sum_next;
            ovf_reg      <= ovf_next;
            window_reg   <= window_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg     <= now_next;
        rate_reg    <= rate_next;
        win_reg     <= win_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
`ifndef ASSERT_OFF
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_W'(CAPACITY))
        else $error("occupancy above ring capacity");

    a_empty_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (occ_reg == '0) |-> (sum_reg == '0))
        else $error("running sum nonzero with empty ring");

    a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == twa_pkg::ST_DIVIDE) && (occ_reg != '0))
        else $error("divider finished outside divide state or with empty ring");

    a_start_evict: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg == twa_pkg::ST_EVICT) && $stable(occ_reg))
        else $error("accepted sample did not enter the eviction walk");
`endif

endmodule

>>> rtl/core/twa_ram.sv
// ----------------------------------------------------------------------------
// twa_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module twa_ram #(
    parameter int WIDTH = 49,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/twa_div.sv
// ----------------------------------------------------------------------------
// twa_div
// Restoring divider, one quotient bit per cycle. The caller guarantees that
// the quotient fits in RATE_W bits (dividend high part below the divisor).
// ----------------------------------------------------------------------------
module twa_div #(
    parameter int OCC_W = 10
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [twa_pkg::RATE_W+OCC_W-1:0]    dividend,
    input  logic [OCC_W-1:0]                    divisor,
    output logic [twa_pkg::RATE_W-1:0]          quotient,
    output logic                                done
);

    localparam int RATE_W = twa_pkg::RATE_W;
    localparam int CNT_W  = $clog2(RATE_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [OCC_W-1:0]  rem_reg, rem_next;
    logic [OCC_W-1:0]  dvs_reg, dvs_next;
    logic [RATE_W-1:0] quo_reg, quo_next;
    logic [OCC_W:0]    trial;
    logic [OCC_W:0]    diff;
    logic              fits;

    assign trial = {rem_reg, quo_reg[RATE_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = dividend[RATE_W+OCC_W-1:RATE_W];
            quo_next  = dividend[RATE_W-1:0];
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            // shift in the next dividend bit, subtract where it fits
            rem_next = fits ? diff[OCC_W-1:0] : trial[OCC_W-1:0];
            quo_next = {quo_reg[RATE_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(RATE_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

>>> tb/sv/time_window_average_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// time_window_average_test
// Self-checking bench for the sliding time-window averager: a short table of
// directed samples and register writes, then randomized window phases. Typed rows
// are scored on table values, others on a behavioral model of ring and running sum.
// ----------------------------------------------------------------------------
module time_window_average_test;

    localparam int TIME_W       = twa_pkg::TIME_W;
    localparam int RATE_W       = twa_pkg::RATE_W;
    localparam int COUNT_W      = twa_pkg::COUNT_W;
    localparam int APB_ADDR_W   = twa_pkg::APB_ADDR_W;
    localparam int APB_DATA_W   = twa_pkg::APB_DATA_W;
    localparam int S_TDATA_W    = twa_pkg::S_TDATA_W;
    localparam int M_TDATA_W    = twa_pkg::M_TDATA_W;
    localparam int CAPACITY_DEF = twa_pkg::CAPACITY_DEF;

    localparam int HALF_PERIOD  = 10;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int QUIET_CYCLES = 8;
    localparam int PRINT_LIMIT  = 50;
    localparam int STAMP_MAX    = (1 << TIME_W) - 1;

    // register map: the window register and one unused slot
    localparam logic [APB_ADDR_W-1:0] ADDR_WINDOW = {twa_pkg::REG_WINDOW, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_SPARE  = {~twa_pkg::REG_WINDOW, 2'b00};

    typedef struct packed {
        logic               overflow;
        logic [COUNT_W-1:0] count;
        logic [RATE_W-1:0]  mean;
    } window_result_t;

    typedef enum logic {
        ROW_SAMPLE,
        ROW_WRITE
    } row_kind_t;

    // one directed step: a sample (key = arrival time, value = rate) or a
    // register write (key = address, value = write data)
    typedef struct {
        row_kind_t      kind;
        logic [31:0]    key;
        logic [31:0]    value;
        bit             typed;
        window_result_t want;
    } stim_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;    // [16:0] arrival_time, [48:17] rate_sample
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;         // [31:0] average_rate, [41:32] held_count
    logic                   m_tuser;         // [0] overflow
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr = '0;
    logic [APB_DATA_W-1:0]  pwdata = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    time_window_average dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // ------------------------------------------------------------------------
    // Window model: ring of {stamp, rate}, head/tail, count and running sum.
    // ------------------------------------------------------------------------
    twa_pkg::entry_t     held_store [CAPACITY_DEF];
    int                  held_head = 0;
    int                  held_tail = 0;
    logic [10:0]         held_n = '0;
    logic [40:0]         held_sum = '0;
    logic [TIME_W-1:0]   window_reg = twa_pkg::WINDOW_RESET;

    window_result_t      pending_means [$];
    int                  error_count = 0;
    int                  cycle_count = 0;
    int                  burst_left = 0;
    int                  timeline = 0;
    window_result_t      arrived_want;

    // receiver stall pattern
    logic [15:0]         stall_mask = '1;
    logic [5:0]          stall_age = '0;

    task automatic drop_oldest();
        held_sum  = held_sum - {9'd0, held_store[held_head].rate};
        held_head = (held_head + 1) % CAPACITY_DEF;
        held_n    = held_n - 1'b1;
    endtask

    task automatic predict_window_mean(input logic [TIME_W-1:0] stamp,
                                       input logic [RATE_W-1:0] rate,
                                       output window_result_t res);
        logic [TIME_W-1:0] span;
        logic [TIME_W-1:0] oldest;
        logic [40:0]       quotient;
        bit                walking;
        // a zero window still keeps the newest sample
        span = (window_reg == '0) ? 17'd1 : window_reg;
        res = '0;
        walking = 1'b1;
        // evict from the head; a later-stamped head has no age and stops the walk
        while (walking && held_n != 0)
        begin
            oldest = held_store[held_head].stamp;
            if (stamp >= oldest && (stamp - oldest) >= span)
                drop_oldest();
            else
                walking = 1'b0;
        end
        // still full: drop the head regardless of age
        if (held_n >= CAPACITY_DEF)
        begin
            drop_oldest();
            res.overflow = 1'b1;
        end
        held_store[held_tail].stamp = stamp;
        held_store[held_tail].rate  = rate;
        held_tail = (held_tail + 1) % CAPACITY_DEF;
        held_n    = held_n + 1'b1;
        held_sum  = held_sum + {9'd0, rate};
        quotient  = held_sum / {30'd0, held_n};
        res.mean  = quotient[RATE_W-1:0];
        res.count = held_n[COUNT_W-1:0];
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("MISMATCH at %0t: %s got 0x%0h, expected 0x%0h",
                     $time, what, got, want);
    endtask

    // ------------------------------------------------------------------------
    // Configuration port: setup then access; read back the window register.
    // ------------------------------------------------------------------------
    task automatic write_register(input logic [APB_ADDR_W-1:0] addr,
                                  input logic [31:0] data);
        logic [31:0] readback;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        // only the window register exists; other indexes are ignored
        if (addr == ADDR_WINDOW)
            window_reg = data[TIME_W-1:0];
        // confirm the window register holds what the model expects
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        paddr   <= ADDR_WINDOW;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback != {15'd0, window_reg})
            report_mismatch("window readback", readback, {15'd0, window_reg});
    endtask

    // ------------------------------------------------------------------------
    // Sender: bursts of back-to-back transfers separated by random gaps.
    // ------------------------------------------------------------------------
    task automatic send_sample(input logic [TIME_W-1:0] stamp,
                               input logic [RATE_W-1:0] rate,
                               input bit typed,
                               input window_result_t typed_want);
        window_result_t predicted;
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 60)) @(posedge clk);
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - RATE_W - TIME_W){1'b0}}, rate, stamp};
        do @(posedge clk); while (!s_tready);
        // transfer taken: advance the model and queue what must come out
        predict_window_mean(stamp, rate, predicted);
        pending_means.push_back(typed ? typed_want : predicted);
    endtask

    // hold the sender until every expected result has drained
    task automatic settle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_means.size() != 0) @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    // mostly random rates, with both extremes and small values mixed in
    function automatic logic [RATE_W-1:0] pick_rate();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return $urandom_range(0, 65535);
            default: return $urandom;
        endcase
    endfunction

    // one window setting, then a run of samples on a rising timeline with an
    // occasional slightly stale stamp thrown in
    task automatic run_window_phase(input logic [31:0] span, input int items,
                                    input int max_step);
        logic [TIME_W-1:0] stamp;
        settle();
        write_register(ADDR_WINDOW, span);
        repeat (items)
        begin
            if ($urandom_range(0, 15) == 0 && timeline > 50)
            begin
                stamp = TIME_W'(timeline - $urandom_range(1, 50));
            end
            else
            begin
                timeline = timeline + $urandom_range(0, max_step);
                if (timeline > STAMP_MAX)
                    timeline = STAMP_MAX;
                stamp = TIME_W'(timeline);
            end
            send_sample(stamp, pick_rate(), 1'b0, '0);
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver: ready follows a 16-bit stall mask indexed by the low stall-age bits,
    // redrawn when the 6-bit stall age wraps; one draw in three is all ones, giving
    // stretches with no back-pressure at all.
    always @(posedge clk)
    begin
        if (stall_age == '0)
        begin
            if ($urandom_range(0, 2) == 0)
                stall_mask <= '1;
            else
                stall_mask <= 16'($urandom);
        end
        stall_age <= stall_age + 1'b1;
        m_tready  <= stall_mask[stall_age[3:0]];
    end

    // ------------------------------------------------------------------------
    // Scoreboard: compare each output transfer with the oldest expectation.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_means.size() == 0)
            begin
                report_mismatch("result with nothing pending", m_tdata[31:0], '0);
            end
            else
            begin
                arrived_want = pending_means.pop_front();
                if (m_tdata[31:0] != arrived_want.mean)
                    report_mismatch("average_rate", m_tdata[31:0], arrived_want.mean);
                if (m_tdata[41:32] != arrived_want.count)
                    report_mismatch("held_count", {22'd0, m_tdata[41:32]},
                                    {22'd0, arrived_want.count});
                if (m_tuser != arrived_want.overflow)
                    report_mismatch("overflow", {31'd0, m_tuser},
                                    {31'd0, arrived_want.overflow});
            end
        end
    end

    // watchdog: a stuck handshake or a lost result ends the run here
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("time_window_average verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------------
    stim_row_t directed_rows [$];

    function automatic void add_row(input row_kind_t kind, input logic [31:0] key,
                                    input logic [31:0] value, input bit typed,
                                    input logic [31:0] mean, input int count);
        stim_row_t row;
        row.kind          = kind;
        row.key           = key;
        row.value         = value;
        row.typed         = typed;
        row.want.mean     = mean;
        row.want.count    = COUNT_W'(count);
        row.want.overflow = 1'b0;
        directed_rows.push_back(row);
    endfunction

    initial
    begin
        // reset window (300): two full-scale samples at time zero
        add_row(ROW_SAMPLE, 0,    32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 1);
        add_row(ROW_SAMPLE, 0,    32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 2);
        // one second short of the window: nothing leaves
        add_row(ROW_SAMPLE, 299,  32'h0000_0000, 0, '0, 0);
        // exactly one window old: both time-zero samples leave
        add_row(ROW_SAMPLE, 300,  32'h0001_0000, 0, '0, 0);
        // stamp going backwards is stored; the walk stops at a later head
        add_row(ROW_SAMPLE, 100,  32'h0000_0000, 0, '0, 0);
        // far jump clears the whole ring
        add_row(ROW_SAMPLE, 1000, 32'h1234_5678, 1, 32'h1234_5678, 1);
        add_row(ROW_SAMPLE, 1000, 32'h0000_0000, 1, 32'h091A_2B3C, 2);
        add_row(ROW_SAMPLE, 1001, 32'h0000_0001, 0, '0, 0);
        // zero window behaves as one second
        add_row(ROW_WRITE,  ADDR_WINDOW, 32'd0, 0, '0, 0);
        add_row(ROW_SAMPLE, 1002, 32'd5, 1, 32'd5, 1);
        add_row(ROW_SAMPLE, 1002, 32'd7, 1, 32'd6, 2);
        add_row(ROW_SAMPLE, 1003, 32'd9, 1, 32'd9, 1);
        // write to an unused index must leave the window alone
        add_row(ROW_WRITE,  ADDR_SPARE, 32'h0001_FFFF, 0, '0, 0);
        add_row(ROW_SAMPLE, 1005, 32'd3, 1, 32'd3, 1);
        // all-ones write: the window keeps only the low 17 bits
        add_row(ROW_WRITE,  ADDR_WINDOW, 32'hFFFF_FFFF, 0, '0, 0);
        add_row(ROW_SAMPLE, 1005, 32'hFFFF_FFFF, 0, '0, 0);
        add_row(ROW_SAMPLE, 1006, 32'h0000_0000, 0, '0, 0);
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [31:0] readback;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset value of the window register
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        paddr   <= ADDR_WINDOW;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback != {15'd0, twa_pkg::WINDOW_RESET})
            report_mismatch("window after reset", readback,
                            {15'd0, twa_pkg::WINDOW_RESET});

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_WRITE)
            begin
                settle();
                write_register(directed_rows[i].key[APB_ADDR_W-1:0],
                               directed_rows[i].value);
            end
            else
            begin
                send_sample(directed_rows[i].key[TIME_W-1:0], directed_rows[i].value,
                            directed_rows[i].typed, directed_rows[i].want);
            end
        end
        timeline = 1006;

        // narrowest windows: samples leave as soon as they are one window old
        run_window_phase(32'd1, 10, 2);
        run_window_phase(32'd0, 6, 1);
        // short window with a moderate pace
        run_window_phase(32'd20, 20, 8);
        // widest window, frozen clock: fill the ring and run into overflow
        run_window_phase(32'h0001_FFFF, 516, 0);
        // drain the full ring through a mid-size window
        run_window_phase(32'd600, 12, 120);
        // full-day window with big strides up to the top of the stamp field
        run_window_phase(32'd86400, 8, 20000);

        settle();
        if (error_count == 0)
            $display("time_window_average verification clean");
        else
            $display("time_window_average verification failed");
        $finish;
    end

endmodule
